// ===== design/etct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etct_pkg
// Shared types, constants and counter arithmetic for the endpoint counter table.
// ----------------------------------------------------------------------------
package etct_pkg;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic        KIND_IPV4      = 1'b0;
  localparam logic        KIND_ETHER     = 1'b1;
  localparam logic [31:0] CNT_MAX        = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [47:0] addr;
    logic        is_rx;
    logic [15:0] len;
    logic        hit;
    logic        new_row;
    logic        last;
    logic [31:0] tx_pk;
    logic [31:0] tx_by;
    logic [31:0] rx_pk;
    logic [31:0] rx_by;
  } query_t;

  // packet count in [63:32], byte count in [31:0], both saturating
  function automatic logic [63:0] bump(logic [63:0] pair, logic [15:0] len);
    logic [31:0] pk;
    logic [32:0] by;
    pk = (pair[63:32] == CNT_MAX) ? CNT_MAX : pair[63:32] + 32'd1;
    by = {1'b0, pair[31:0]} + {17'd0, len};
    return {pk, by[32] ? CNT_MAX : by[31:0]};
  endfunction

endpackage

// ===== design/etct_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etct_in_if / etct_out_if
// Valid/ready channels for frame summaries and per-row update results.
// ----------------------------------------------------------------------------
interface etct_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_length;
  logic [47:0] dst_mac;
  logic [47:0] src_mac;
  logic [15:0] eth_type;
  logic [31:0] dst_ip;
  logic [31:0] src_ip;

  modport source (output valid, frame_length, dst_mac, src_mac, eth_type, dst_ip, src_ip,
                  input ready);
  modport sink (input valid, frame_length, dst_mac, src_mac, eth_type, dst_ip, src_ip,
                output ready);
endinterface

interface etct_out_if;
  logic        valid;
  logic        ready;
  logic        table_kind;
  logic [47:0] endpoint_address;
  logic [31:0] tx_packet_total;
  logic [31:0] tx_byte_total;
  logic [31:0] rx_packet_total;
  logic [31:0] rx_byte_total;
  logic        new_entry;
  logic        table_full;
  logic        last_result;

  modport source (output valid, table_kind, endpoint_address, tx_packet_total,
                  tx_byte_total, rx_packet_total, rx_byte_total, new_entry, table_full,
                  last_result, input ready);
  modport sink (input valid, table_kind, endpoint_address, tx_packet_total,
                tx_byte_total, rx_packet_total, rx_byte_total, new_entry, table_full,
                last_result, output ready);
endinterface

// ===== design/etct_row.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etct_row
// One table row: address match or insert at the fill point, counter update.
// ----------------------------------------------------------------------------
module etct_row #(
  parameter int  INDEX = 0,
  parameter logic KIND = 1'b0,
  parameter int  CW    = 9
) (
  input  logic              clk,
  input  logic              adv,
  input  logic [CW-1:0]     used,
  input  etct_pkg::query_t  q_in,
  output etct_pkg::query_t  q_out,
  output logic              ins
);
  import etct_pkg::*;

  logic [47:0] addr;
  logic [63:0] tx;
  logic [63:0] rx;

  logic        mine;
  logic        hit_here;
  logic        ins_here;
  logic [63:0] base_tx;
  logic [63:0] base_rx;
  logic [63:0] tx_next;
  logic [63:0] rx_next;

  always_comb begin
    mine     = q_in.valid && (q_in.kind == KIND) && !q_in.hit;
    hit_here = mine && (used > CW'(INDEX)) && (addr == q_in.addr);
    ins_here = mine && (used == CW'(INDEX));
    base_tx  = ins_here ? 64'd0 : tx;
    base_rx  = ins_here ? 64'd0 : rx;
    tx_next  = q_in.is_rx ? base_tx : bump(base_tx, q_in.len);
    rx_next  = q_in.is_rx ? bump(base_rx, q_in.len) : base_rx;
    q_out    = q_in;
    if (hit_here || ins_here) begin
      q_out.hit     = 1'b1;
      q_out.new_row = ins_here;
      q_out.tx_pk   = tx_next[63:32];
      q_out.tx_by   = tx_next[31:0];
      q_out.rx_pk   = rx_next[63:32];
      q_out.rx_by   = rx_next[31:0];
    end
  end

  assign ins = adv && ins_here;

  always_ff @(posedge clk) begin
    if (adv && (hit_here || ins_here)) begin
      addr <= q_in.addr;
      tx   <= tx_next;
      rx   <= rx_next;
    end
  end

endmodule

// ===== design/etct_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etct_stage
// Chain cell: one IPv4 row and/or one Ethernet row plus the query register.
// ----------------------------------------------------------------------------
module etct_stage #(
  parameter int INDEX   = 0,
  parameter bit HAS_IP  = 1'b1,
  parameter bit HAS_ETH = 1'b1,
  parameter int IP_CW   = 9,
  parameter int ETH_CW  = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic [IP_CW-1:0]  ip_used,
  input  logic [ETH_CW-1:0] eth_used,
  input  etct_pkg::query_t  q_in,
  output etct_pkg::query_t  q_out,
  output logic              ip_ins,
  output logic              eth_ins
);
  import etct_pkg::*;

  query_t q_mid;
  query_t q_next;

  if (HAS_IP) begin : g_ip
    etct_row #(.INDEX(INDEX), .KIND(KIND_IPV4), .CW(IP_CW)) u_row (
      .clk(clk), .adv(adv), .used(ip_used), .q_in(q_in), .q_out(q_mid), .ins(ip_ins)
    );
  end else begin : g_no_ip
    assign q_mid  = q_in;
    assign ip_ins = 1'b0;
  end

  if (HAS_ETH) begin : g_eth
    etct_row #(.INDEX(INDEX), .KIND(KIND_ETHER), .CW(ETH_CW)) u_row (
      .clk(clk), .adv(adv), .used(eth_used), .q_in(q_mid), .q_out(q_next), .ins(eth_ins)
    );
  end else begin : g_no_eth
    assign q_next  = q_mid;
    assign eth_ins = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_out.valid <= 1'b0;
    end else if (adv) begin
      q_out <= q_next;
    end
  end

endmodule

// ===== design/endpoint_traffic_counter_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// endpoint_traffic_counter_table_core
// Per-endpoint Tx/Rx packet and byte counters for IPv4 and Ethernet addresses.
// ----------------------------------------------------------------------------
// Each accepted frame is issued by the sequencer as four row updates (IPv4) or two
// (other); one row update per cycle enters the row chain while the result sink is
//   not stalling, and a new frame is accepted as the previous frame's last update issues.
// Updates flow through a chain of row cells, one cell per cycle while not stalled, in order.
// Reset clears the fill counts and the pipeline valids; rows are not cleared.
module endpoint_traffic_counter_table_core #(
  parameter int IPV4_ROWS  = 256,
  parameter int ETHER_ROWS = 256
) (
  input logic        clk,
  input logic        rst,
  etct_in_if.sink    frame,
  etct_out_if.source result
);
  import etct_pkg::*;

  localparam int L      = (IPV4_ROWS > ETHER_ROWS) ? IPV4_ROWS : ETHER_ROWS;
  localparam int IP_CW  = $clog2(IPV4_ROWS + 1);
  localparam int ETH_CW = $clog2(ETHER_ROWS + 1);

  typedef enum logic [1:0] {ST_IP_DST, ST_IP_SRC, ST_ETH_DST, ST_ETH_SRC} step_t;

  step_t       step;
  logic        busy;
  logic [15:0] f_len;
  logic [47:0] f_dmac;
  logic [47:0] f_smac;
  logic [31:0] f_dip;
  logic [31:0] f_sip;

  logic              adv;
  logic              accept;
  query_t            q [0:L];
  query_t            res;
  logic [L-1:0]      ip_ins_v;
  logic [L-1:0]      eth_ins_v;
  logic [IP_CW-1:0]  ip_used;
  logic [ETH_CW-1:0] eth_used;

  assign adv         = !res.valid || result.ready;
  assign frame.ready = !busy || (adv && step == ST_ETH_SRC);
  assign accept      = frame.valid && frame.ready;

  always_comb begin
    q[0]         = '0;
    q[0].valid   = busy;
    q[0].len     = f_len;
    q[0].last    = (step == ST_ETH_SRC);
    case (step)
      ST_IP_DST: begin
        q[0].kind  = KIND_IPV4;
        q[0].addr  = {16'd0, f_dip};
        q[0].is_rx = 1'b1;
      end
      ST_IP_SRC: begin
        q[0].kind  = KIND_IPV4;
        q[0].addr  = {16'd0, f_sip};
        q[0].is_rx = 1'b0;
      end
      ST_ETH_DST: begin
        q[0].kind  = KIND_ETHER;
        q[0].addr  = f_dmac;
        q[0].is_rx = 1'b1;
      end
      default: begin
        q[0].kind  = KIND_ETHER;
        q[0].addr  = f_smac;
        q[0].is_rx = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= ST_IP_DST;
    end else begin
      if (adv && busy) begin
        if (step == ST_ETH_SRC) begin
          busy <= 1'b0;
        end else begin
          step <= step_t'(step + 2'd1);
        end
      end
      if (accept) begin
        busy <= 1'b1;
        step <= (frame.eth_type == ETHERTYPE_IPV4) ? ST_IP_DST : ST_ETH_DST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_len  <= frame.frame_length;
      f_dmac <= frame.dst_mac;
      f_smac <= frame.src_mac;
      f_dip  <= frame.dst_ip;
      f_sip  <= frame.src_ip;
    end
  end

  for (genvar s = 0; s < L; s++) begin : g_cell
    etct_stage #(
      .INDEX(s), .HAS_IP(s < IPV4_ROWS), .HAS_ETH(s < ETHER_ROWS),
      .IP_CW(IP_CW), .ETH_CW(ETH_CW)
    ) u_stage (
      .clk(clk), .rst(rst), .adv(adv), .ip_used(ip_used), .eth_used(eth_used),
      .q_in(q[s]), .q_out(q[s+1]), .ip_ins(ip_ins_v[s]), .eth_ins(eth_ins_v[s])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ip_used  <= '0;
      eth_used <= '0;
    end else begin
      if (|ip_ins_v) begin
        ip_used <= ip_used + IP_CW'(1);
      end
      if (|eth_ins_v) begin
        eth_used <= eth_used + ETH_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (adv) begin
      res <= q[L];
    end
  end

  assign result.valid            = res.valid;
  assign result.table_kind       = res.kind;
  assign result.endpoint_address = res.addr;
  assign result.tx_packet_total  = res.tx_pk;
  assign result.tx_byte_total    = res.tx_by;
  assign result.rx_packet_total  = res.rx_pk;
  assign result.rx_byte_total    = res.rx_by;
  assign result.new_entry        = res.new_row;
  assign result.table_full       = !res.hit;
  assign result.last_result      = res.last;

  a_ip_used_bound: assert property (@(posedge clk) disable iff (rst)
    ip_used <= IP_CW'(IPV4_ROWS)) else $error("ipv4 fill count overran table");
  a_eth_used_bound: assert property (@(posedge clk) disable iff (rst)
    eth_used <= ETH_CW'(ETHER_ROWS)) else $error("ether fill count overran table");
  a_one_ins: assert property (@(posedge clk) disable iff (rst)
    $onehot0(ip_ins_v) && $onehot0(eth_ins_v)) else $error("multiple row inserts");
  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    (|ip_ins_v) |=> ip_used == $past(ip_used) + IP_CW'(1))
    else $error("ipv4 insert not counted");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("accepted frame not issued");

endmodule

// ===== sim/etct_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etct_checker
// Watches the frame and result channels of the endpoint counter table. Keeps
// its own copy of both endpoint tables, predicts the row totals for each
// accepted frame and compares every result beat against the oldest one due.
// ----------------------------------------------------------------------------
module etct_checker #(
  parameter int ROWS = 256
) (
  input  logic clk,
  input  logic rst,
  etct_in_if   frame,
  etct_out_if  result,
  output int   errors,
  output int   pending
);
  import etct_pkg::*;

  typedef struct {
    logic        kind;
    logic [47:0] addr;
    logic [31:0] tx_pk;
    logic [31:0] tx_by;
    logic [31:0] rx_pk;
    logic [31:0] rx_by;
    logic        new_entry;
    logic        full;
    logic        last;
  } row_totals_t;

  row_totals_t totals_due[$];

  logic [47:0] row_addr [2][ROWS];
  logic [31:0] row_tx_pk[2][ROWS];
  logic [31:0] row_tx_by[2][ROWS];
  logic [31:0] row_rx_pk[2][ROWS];
  logic [31:0] row_rx_by[2][ROWS];
  int          rows_used[2];

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? CNT_MAX : s[31:0];
  endfunction

  function automatic void count_row(logic kind, logic [47:0] addr, logic is_rx,
                                    logic [15:0] len, logic last);
    row_totals_t t;
    int          i;
    int          hit;
    hit = -1;
    for (i = 0; i < rows_used[kind]; i++) begin
      if (hit < 0 && row_addr[kind][i] == addr) hit = i;
    end
    t.kind = kind;
    t.addr = addr;
    t.last = last;
    t.new_entry = 1'b0;
    t.full = 1'b0;
    if (hit < 0 && rows_used[kind] >= ROWS) begin
      t.full = 1'b1;
      t.tx_pk = '0;
      t.tx_by = '0;
      t.rx_pk = '0;
      t.rx_by = '0;
    end else begin
      if (hit < 0) begin
        hit = rows_used[kind];
        rows_used[kind]++;
        row_addr[kind][hit] = addr;
        row_tx_pk[kind][hit] = '0;
        row_tx_by[kind][hit] = '0;
        row_rx_pk[kind][hit] = '0;
        row_rx_by[kind][hit] = '0;
        t.new_entry = 1'b1;
      end
      if (is_rx) begin
        row_rx_pk[kind][hit] = sat_sum(row_rx_pk[kind][hit], 32'd1);
        row_rx_by[kind][hit] = sat_sum(row_rx_by[kind][hit], {16'd0, len});
      end else begin
        row_tx_pk[kind][hit] = sat_sum(row_tx_pk[kind][hit], 32'd1);
        row_tx_by[kind][hit] = sat_sum(row_tx_by[kind][hit], {16'd0, len});
      end
      t.tx_pk = row_tx_pk[kind][hit];
      t.tx_by = row_tx_by[kind][hit];
      t.rx_pk = row_rx_pk[kind][hit];
      t.rx_by = row_rx_by[kind][hit];
    end
    totals_due.push_back(t);
  endfunction

  function automatic void check_field(string name, logic [47:0] exp, logic [47:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    row_totals_t t;
    if (rst) begin
      rows_used[0] = 0;
      rows_used[1] = 0;
      totals_due.delete();
    end else begin
      if (frame.valid && frame.ready) begin
        if (frame.eth_type == ETHERTYPE_IPV4) begin
          count_row(KIND_IPV4, {16'd0, frame.dst_ip}, 1'b1, frame.frame_length, 1'b0);
          count_row(KIND_IPV4, {16'd0, frame.src_ip}, 1'b0, frame.frame_length, 1'b0);
        end
        count_row(KIND_ETHER, frame.dst_mac, 1'b1, frame.frame_length, 1'b0);
        count_row(KIND_ETHER, frame.src_mac, 1'b0, frame.frame_length, 1'b1);
      end
      if (result.valid && result.ready) begin
        if (totals_due.size() == 0) begin
          $error("result beat with no update outstanding");
          errors++;
        end else begin
          t = totals_due.pop_front();
          check_field("table_kind", t.kind, result.table_kind);
          check_field("endpoint_address", t.addr, result.endpoint_address);
          check_field("tx_packet_total", t.tx_pk, result.tx_packet_total);
          check_field("tx_byte_total", t.tx_by, result.tx_byte_total);
          check_field("rx_packet_total", t.rx_pk, result.rx_packet_total);
          check_field("rx_byte_total", t.rx_by, result.rx_byte_total);
          check_field("new_entry", t.new_entry, result.new_entry);
          check_field("table_full", t.full, result.table_full);
          check_field("last_result", t.last, result.last_result);
        end
      end
    end
    pending <= totals_due.size();
  end

  initial begin
    errors = 0;
    pending = 0;
  end

endmodule

// ===== sim/tb_endpoint_traffic_counter_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_endpoint_traffic_counter_table_core
// Drives frame summaries into the endpoint counter table: directed corner
// frames, then random traffic over pooled and random addresses, under several source
// idle and sink stall mixes.
// ----------------------------------------------------------------------------
module tb_endpoint_traffic_counter_table_core;
  import etct_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 600;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   cycles;
  int   idle_pct;
  int   stall_pct;

  etct_in_if  frame_ch();
  etct_out_if result_ch();

  endpoint_traffic_counter_table_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .frame  (frame_ch.sink),
    .result (result_ch.source)
  );

  etct_checker i_checker (
    .clk     (clk),
    .rst     (rst),
    .frame   (frame_ch),
    .result  (result_ch),
    .errors  (errors),
    .pending (pending)
  );

  logic [47:0] mac_pool[16];
  logic [31:0] ip_pool[16];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL endpoint_traffic_counter_table_core");
      $finish;
    end
  end

  always @(negedge clk) begin
    result_ch.ready = ($urandom_range(99) >= stall_pct);
  end

  task automatic send_frame(logic [15:0] len, logic [47:0] dmac, logic [47:0] smac,
                            logic [15:0] etype, logic [31:0] dip, logic [31:0] sip);
    while ($urandom_range(99) < idle_pct) begin
      frame_ch.valid = 1'b0;
      @(negedge clk);
    end
    frame_ch.valid = 1'b1;
    frame_ch.frame_length = len;
    frame_ch.dst_mac = dmac;
    frame_ch.src_mac = smac;
    frame_ch.eth_type = etype;
    frame_ch.dst_ip = dip;
    frame_ch.src_ip = sip;
    do @(posedge clk); while (!frame_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    frame_ch.valid = 1'b0;
    while (pending != 0 || frame_ch.ready === 1'bx) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic random_frames(int n);
    logic [47:0] dmac;
    logic [47:0] smac;
    logic [31:0] dip;
    logic [31:0] sip;
    logic [15:0] etype;
    logic [15:0] len;
    for (int k = 0; k < n; k++) begin
      dmac = ($urandom_range(1)) ? mac_pool[$urandom_range(15)]
                                 : 48'({$urandom, $urandom});
      smac = ($urandom_range(3) == 0) ? dmac
           : ($urandom_range(1)) ? mac_pool[$urandom_range(15)]
                                 : 48'({$urandom, $urandom});
      dip = ($urandom_range(1)) ? ip_pool[$urandom_range(15)] : $urandom;
      sip = ($urandom_range(3) == 0) ? dip
          : ($urandom_range(1)) ? ip_pool[$urandom_range(15)] : $urandom;
      etype = ($urandom_range(9) < 7) ? ETHERTYPE_IPV4 : 16'($urandom);
      len = ($urandom_range(4) == 0) ? 16'hFFFF : 16'($urandom_range(1500));
      if ($urandom_range(7) == 0) len = 16'($urandom);
      send_frame(len, dmac, smac, etype, dip, sip);
    end
  endtask

  initial begin
    cycles = 0;
    idle_pct = 0;
    stall_pct = 0;
    rst = 1'b1;
    frame_ch.valid = 1'b0;
    frame_ch.frame_length = '0;
    frame_ch.dst_mac = '0;
    frame_ch.src_mac = '0;
    frame_ch.eth_type = '0;
    frame_ch.dst_ip = '0;
    frame_ch.src_ip = '0;
    result_ch.ready = 1'b1;
    for (int i = 0; i < 16; i++) begin
      mac_pool[i] = 48'({$urandom, $urandom});
      ip_pool[i] = $urandom;
    end
    mac_pool[0] = '0;
    mac_pool[1] = 48'hFFFF_FFFF_FFFF;
    ip_pool[0] = '0;
    ip_pool[1] = 32'hFFFF_FFFF;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // corner frames: extremes, same src/dst, non-IPv4 with IP fields set
    send_frame(16'd0, 48'd0, 48'd0, ETHERTYPE_IPV4, 32'd0, 32'd0);
    send_frame(16'hFFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, ETHERTYPE_IPV4,
               32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_frame(16'd60, 48'd0, 48'hFFFF_FFFF_FFFF, ETHERTYPE_IPV4, 32'd0, 32'hFFFF_FFFF);
    send_frame(16'd64, mac_pool[2], mac_pool[3], 16'h0801, 32'hDEAD_BEEF, 32'h1234_5678);
    send_frame(16'd1514, mac_pool[3], mac_pool[2], 16'h0000, 32'd0, 32'd0);
    send_frame(16'd1, mac_pool[4], mac_pool[4], 16'hFFFF, 32'hFFFF_FFFF, 32'd0);
    send_frame(16'h8000, mac_pool[2], mac_pool[4], 16'h86DD, ip_pool[2], ip_pool[3]);
    send_frame(16'd14, mac_pool[5], mac_pool[6], ETHERTYPE_IPV4, ip_pool[3], ip_pool[2]);
    send_frame(16'd14, mac_pool[6], mac_pool[5], ETHERTYPE_IPV4, ip_pool[2], ip_pool[2]);
    send_frame(16'h7FFF, mac_pool[0], mac_pool[1], ETHERTYPE_IPV4, ip_pool[4], ip_pool[0]);
    drain();

    idle_pct = 0;  stall_pct = 0;  random_frames(60);
    idle_pct = 66; stall_pct = 0;  random_frames(60);
    drain();
    idle_pct = 0;  stall_pct = 66; random_frames(60);
    idle_pct = 11; stall_pct = 11; random_frames(60);
    idle_pct = 0;  stall_pct = 0;  random_frames(20);
    drain();

    if (errors == 0) begin
      $display("PASS endpoint_traffic_counter_table_core");
    end else begin
      $display("FAIL endpoint_traffic_counter_table_core");
    end
    $finish;
  end

endmodule
